/* rtl/rme_pkg.sv */
// ----------------------------------------------------------------------------
// rotation matrix to euler angles - shared package
// cordic angle table, fixed-point constants and pipeline beat types
// ----------------------------------------------------------------------------
package rme_pkg;

   localparam int ElemWidth   = 16;
   localparam int AngleWidth  = 16;
   localparam int ThreshWidth = 15;
   localparam int AtanLen     = 24;
   // cordic datapath: 17-bit magnitude scaled by 2^8 plus growth and sign
   localparam int VecWidth    = 28;
   localparam int AccWidth    = 34;
   localparam int SqrtWidth   = 29;

   localparam logic signed [AngleWidth-1:0] HalfPiQ13 = 16'sd12868;
   localparam logic signed [AccWidth-1:0]   PiQ30     = 34'sd3373259426;
   localparam logic signed [17:0]           OneQ14    = 18'sd16384;
   localparam logic [ThreshWidth-1:0]       ThreshReset = 15'd16382;

   // one cordic lane in flight
   typedef struct packed {
      logic signed [VecWidth-1:0] x;
      logic signed [VecWidth-1:0] y;
      logic signed [AccWidth-1:0] z;
      logic                       zero;
   } cordic_lane_type;

   // side data that travels alongside the lanes
   typedef struct packed {
      logic                         locked;
      logic                         sat;
      logic signed [AngleWidth-1:0] sat_pitch;
   } side_type;

   function automatic logic signed [AccWidth-1:0] atan_q30(input int i);
      logic signed [AccWidth-1:0] t;
      begin
         case (i)
            0: t = 34'sd843314856;
            1: t = 34'sd497837829;
            2: t = 34'sd263043836;
            3: t = 34'sd133525158;
            4: t = 34'sd67021686;
            5: t = 34'sd33543515;
            6: t = 34'sd16775850;
            7: t = 34'sd8388437;
            8: t = 34'sd4194282;
            9: t = 34'sd2097149;
            10: t = 34'sd1048575;
            11: t = 34'sd524287;
            12: t = 34'sd262143;
            13: t = 34'sd131071;
            14: t = 34'sd65535;
            15: t = 34'sd32767;
            16: t = 34'sd16383;
            17: t = 34'sd8191;
            18: t = 34'sd4095;
            19: t = 34'sd2047;
            20: t = 34'sd1023;
            21: t = 34'sd511;
            22: t = 34'sd255;
            23: t = 34'sd127;
            default: t = '0;
         endcase
         return t;
      end
   endfunction

endpackage

/* rtl/rme_sqrt.sv */
// ----------------------------------------------------------------------------
// rme_sqrt - pipelined integer square root
// one result bit per stage, restoring method, an item enters every cycle
// ----------------------------------------------------------------------------
module rme_sqrt
   import rme_pkg::*;
#(
   parameter int SideWidth = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [SqrtWidth-1:0]   in_radicand,
   input  logic [SideWidth-1:0]   in_side,
   output logic                   out_valid,
   output logic [14:0]            out_root,
   output logic [SideWidth-1:0]   out_side
);
   localparam int Steps = 15;

   logic [Steps:0]                 valid_ff;
   logic [SqrtWidth-1:0]           rem_ff  [Steps+1];
   logic [14:0]                    root_ff [Steps+1];
   logic [SideWidth-1:0]           side_ff [Steps+1];

   // stage zero takes the operand
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0]  <= in_radicand;
      root_ff[0] <= '0;
      side_ff[0] <= in_side;
   end

   // one root bit a stage, from the top
   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [SqrtWidth:0] trial;
      logic [SqrtWidth:0] rem_in;
      logic [14:0]        root_in;
      always_comb begin
         trial   = ({15'd0, root_ff[s]} << (Steps - s))
                   | ((SqrtWidth+1)'(1) << (2*(Steps-1-s)));
         if ({1'b0, rem_ff[s]} >= trial) begin
            rem_in  = {1'b0, rem_ff[s]} - trial;
            root_in = root_ff[s] | (15'd1 << (Steps-1-s));
         end else begin
            rem_in  = {1'b0, rem_ff[s]};
            root_in = root_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         rem_ff[s+1]  <= rem_in[SqrtWidth-1:0];
         root_ff[s+1] <= root_in;
         side_ff[s+1] <= side_ff[s];
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_root  = root_ff[Steps];
   assign out_side  = side_ff[Steps];

endmodule

/* rtl/rme_cordic.sv */
// ----------------------------------------------------------------------------
// rme_cordic - unrolled vectoring cordic lane
// quadrant fold then one micro-rotation per registered stage, rounded angle out
// ----------------------------------------------------------------------------
module rme_cordic
   import rme_pkg::*;
#(
   parameter int Stages = 16
) (
   input  logic                          clock,
   input  logic signed [17:0]            in_y,
   input  logic signed [17:0]            in_x,
   output logic signed [AngleWidth-1:0]  out_angle
);
   cordic_lane_type lane_ff [Stages+1];
   cordic_lane_type lane_in;
   logic signed [AngleWidth-1:0] angle_ff;
   logic signed [AccWidth-1:0]   rnd;

   // pre-scale and fold into the right half plane
   always_comb begin
      lane_in.x    = VecWidth'(in_x) <<< 8;
      lane_in.y    = VecWidth'(in_y) <<< 8;
      lane_in.z    = '0;
      lane_in.zero = (in_x == 18'sd0) && (in_y == 18'sd0);
      if (in_x < 0) begin
         lane_in.z = (in_y >= 0) ? PiQ30 : -PiQ30;
         lane_in.x = -lane_in.x;
         lane_in.y = -lane_in.y;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff[0] <= lane_in;
   end

   // micro-rotations
   for (genvar i = 0; i < Stages; i++) begin : g_stage
      cordic_lane_type nxt;
      always_comb begin
         nxt = lane_ff[i];
         if (lane_ff[i].y < 0) begin
            nxt.x = lane_ff[i].x - (lane_ff[i].y >>> i);
            nxt.y = lane_ff[i].y + (lane_ff[i].x >>> i);
            nxt.z = lane_ff[i].z - atan_q30(i);
         end else begin
            nxt.x = lane_ff[i].x + (lane_ff[i].y >>> i);
            nxt.y = lane_ff[i].y - (lane_ff[i].x >>> i);
            nxt.z = lane_ff[i].z + atan_q30(i);
         end
      end
      always_ff @(posedge clock) begin
         lane_ff[i+1] <= nxt;
      end
   end

   // round half up to q3.13
   assign rnd = lane_ff[Stages].z + AccWidth'(65536);
   always_ff @(posedge clock) begin
      angle_ff <= lane_ff[Stages].zero ? '0 : AngleWidth'(rnd >>> 17);
   end
   assign out_angle = angle_ff;

endmodule

/* rtl/rotation_matrix_to_euler_top.sv */
// ----------------------------------------------------------------------------
// rotation matrix to euler top
// pitch, yaw and roll from seven rotation matrix elements
// ----------------------------------------------------------------------------
// Usage: drive the seven q1.14 elements on req_* and pulse req_start; a beat
// is taken at every edge with req_start high and req_busy low. req_busy is
// held low, so a matrix may enter every cycle (one beat per cycle).
// Results leave on rsp_* with rsp_valid high for exactly one cycle, in the
// order of entry; between the accepting edge and rsp_valid lie 16 register
// stages of pipelined square root for the pitch cosine, then the cordic
// input register holding the fold, CORDIC_STAGES micro-rotation stages and
// the rounding register.
// The lock threshold is written through csr_valid/csr_ready (always ready); the user
// writes it while the block is idle, which the block does not enforce; it resets to 16382.
// Synchronous reset empties the pipeline valid bits; no result is lost
// through stalls since the receiver cannot hold results off.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_top
   import rme_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_start,
   output logic                          req_busy,
   input  logic signed [ElemWidth-1:0]   req_row1_col1,
   input  logic signed [ElemWidth-1:0]   req_row1_col2,
   input  logic signed [ElemWidth-1:0]   req_row1_col3,
   input  logic signed [ElemWidth-1:0]   req_row2_col2,
   input  logic signed [ElemWidth-1:0]   req_row3_col1,
   input  logic signed [ElemWidth-1:0]   req_row3_col2,
   input  logic signed [ElemWidth-1:0]   req_row3_col3,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ThreshWidth-1:0]        csr_lock_threshold,
   output logic                          rsp_valid,
   output logic signed [AngleWidth-1:0]  rsp_pitch_angle,
   output logic signed [AngleWidth-1:0]  rsp_yaw_angle,
   output logic signed [AngleWidth-1:0]  rsp_roll_angle,
   output logic                          rsp_gimbal_locked
);
   localparam int CordLat = CORDIC_STAGES + 2;
   localparam int SideW   = 5 * 18 + $bits(side_type);

   logic [ThreshWidth-1:0] thresh_ff;
   logic                   accept;
   logic signed [17:0]     sp, mag;
   logic [SqrtWidth-1:0]   rad;
   side_type               side;
   logic [SideW-1:0]       sq_side_in, sq_side;
   logic                   sq_valid;
   logic [14:0]            root;

   assign req_busy  = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = req_start && !req_busy;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= ThreshReset;
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_lock_threshold;
      end
   end

   // pitch sine, lock decision and cosine radicand
   always_comb begin
      sp  = -18'(req_row3_col2);
      mag = (sp < 0) ? -sp : sp;
      side.locked = mag > {3'd0, thresh_ff};
      side.sat    = (sp <= -OneQ14) || (sp >= OneQ14);
      side.sat_pitch = (sp < 0) ? -HalfPiQ13 : HalfPiQ13;
      rad = side.sat ? '0 : SqrtWidth'(36'sd268435456 - 36'(sp) * 36'(sp));
      sq_side_in = {side, sp,
                    side.locked ? -18'(req_row1_col3) : 18'(req_row3_col1),
                    side.locked ? 18'(req_row1_col1)  : 18'(req_row3_col3),
                    18'(req_row1_col2), 18'(req_row2_col2)};
   end

   rme_sqrt #(.SideWidth(SideW)) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_radicand (rad),
      .in_side     (sq_side_in),
      .out_valid   (sq_valid),
      .out_root    (root),
      .out_side    (sq_side)
   );

   side_type           s_side;
   logic signed [17:0] s_sp, s_ya, s_yb, s_ra, s_rb;
   assign {s_side, s_sp, s_ya, s_yb, s_ra, s_rb} = sq_side;

   logic signed [AngleWidth-1:0] pitch_c, yaw_c, roll_c;

   rme_cordic #(.Stages(CORDIC_STAGES)) u_pitch (
      .clock (clock), .in_y (s_sp), .in_x ({3'd0, root}), .out_angle (pitch_c));
   rme_cordic #(.Stages(CORDIC_STAGES)) u_yaw (
      .clock (clock), .in_y (s_ya), .in_x (s_yb), .out_angle (yaw_c));
   rme_cordic #(.Stages(CORDIC_STAGES)) u_roll (
      .clock (clock), .in_y (s_ra), .in_x (s_rb), .out_angle (roll_c));

   // valid and side delay line matching the cordic lanes
   logic     vd_ff [CordLat];
   side_type sd_ff [CordLat];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CordLat; k++) vd_ff[k] <= 1'b0;
      end else begin
         vd_ff[0] <= sq_valid;
         for (int k = 1; k < CordLat; k++) vd_ff[k] <= vd_ff[k-1];
      end
      sd_ff[0] <= s_side;
      for (int k = 1; k < CordLat; k++) sd_ff[k] <= sd_ff[k-1];
   end

   // result beat
   assign rsp_valid         = vd_ff[CordLat-1];
   assign rsp_gimbal_locked = sd_ff[CordLat-1].locked;
   assign rsp_pitch_angle   = sd_ff[CordLat-1].sat ? sd_ff[CordLat-1].sat_pitch : pitch_c;
   assign rsp_yaw_angle     = yaw_c;
   assign rsp_roll_angle    = sd_ff[CordLat-1].locked ? '0 : roll_c;

   // checks
   a_lock_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gimbal_locked |-> rsp_roll_angle == '0)
      else $error("roll not zero while locked");
   a_sat_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sd_ff[CordLat-1].sat |->
      (rsp_pitch_angle == HalfPiQ13 || rsp_pitch_angle == -HalfPiQ13))
      else $error("saturated pitch wrong");
   a_sqrt_flow: assert property (@(posedge clock) disable iff (reset)
      sq_valid |=> vd_ff[0])
      else $error("beat lost after square root");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// rotation matrix to euler - block testbench
// drives matrix beats and lock threshold settings, predicts each angle set
// with a local cordic model and checks every result beat in order
// ----------------------------------------------------------------------------
module tb_top
   import rme_pkg::*;
();

   localparam int Stages    = 16;
   localparam int Latency   = Stages + 20;
   localparam int WatchLimit = 400;

   typedef struct {
      logic signed [15:0] m11, m12, m13, m22, m31, m32, m33;
   } matrix_type;

   typedef struct {
      logic signed [15:0] pitch, yaw, roll;
      logic               locked;
   } angles_type;

   // directed row: matrix, optional typed-in answer
   typedef struct {
      matrix_type m;
      bit         known;
      angles_type a;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_start = 0;
   logic req_busy;
   logic signed [15:0] req_row1_col1 = 0, req_row1_col2 = 0, req_row1_col3 = 0;
   logic signed [15:0] req_row2_col2 = 0, req_row3_col1 = 0, req_row3_col2 = 0;
   logic signed [15:0] req_row3_col3 = 0;
   logic csr_valid = 0;
   logic csr_ready;
   logic [14:0] csr_lock_threshold = 0;
   logic rsp_valid;
   logic signed [15:0] rsp_pitch_angle, rsp_yaw_angle, rsp_roll_angle;
   logic rsp_gimbal_locked;

   rotation_matrix_to_euler_top #(.CORDIC_STAGES(Stages)) i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   angles_type  pending_angles[$];
   logic [14:0] threshold_shadow;
   int          errors = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          locked_seen = 0;
   int          idle_cycles = 0;
   int          send_gap = 0;

   // --------------------------------------------------------------------
   // predictor
   // --------------------------------------------------------------------
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [15:0] cordic_angle(longint y, longint x);
      longint z, xs, ys;
      longint tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
         33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
         262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
         255, 127};
      z = 0;
      if (x == 0 && y == 0) return 16'sd0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < Stages && i < 24; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y < 0) begin
            x = x - ys; y = y + xs; z = z - tab[i];
         end else begin
            x = x + ys; y = y - xs; z = z + tab[i];
         end
      end
      return 16'(floor_shift(z + 65536, 17));
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r = 0;
      longint b = 64'd1 << 30;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic angles_type euler_of(matrix_type m, logic [14:0] thr);
      angles_type a;
      longint sp, mag;
      sp  = -longint'(m.m32);
      mag = sp < 0 ? -sp : sp;
      if (sp <= -16384) a.pitch = -HalfPiQ13;
      else if (sp >= 16384) a.pitch = HalfPiQ13;
      else a.pitch = cordic_angle(sp, int_sqrt(64'd268435456 - sp * sp));
      a.locked = mag > longint'(thr);
      if (a.locked) begin
         a.roll = 0;
         a.yaw  = cordic_angle(-longint'(m.m13), longint'(m.m11));
      end else begin
         a.yaw  = cordic_angle(longint'(m.m31), longint'(m.m33));
         a.roll = cordic_angle(longint'(m.m12), longint'(m.m22));
      end
      return a;
   endfunction

   // --------------------------------------------------------------------
   // result checking, sampled at the edge that ends the beat
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      angles_type e;
      if (!reset && rsp_valid) begin
         beats_out++;
         if (pending_angles.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat", $time);
         end else begin
            e = pending_angles.pop_front();
            if (rsp_gimbal_locked) locked_seen++;
            if (rsp_pitch_angle !== e.pitch || rsp_yaw_angle !== e.yaw ||
                rsp_roll_angle !== e.roll || rsp_gimbal_locked !== e.locked) begin
               errors++;
               $display("%0t: expected p=%0d y=%0d r=%0d l=%0d actual p=%0d y=%0d r=%0d l=%0d",
                  $time, e.pitch, e.yaw, e.roll, e.locked, rsp_pitch_angle,
                  rsp_yaw_angle, rsp_roll_angle, rsp_gimbal_locked);
            end
         end
      end
   end

   // watchdog on cycles with no beat taken in or out
   always @(posedge clock) begin
      if ((req_start && !req_busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // --------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------
   task automatic send_matrix(matrix_type m, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_start <= 0;
         @(posedge clock);
      end
      req_start     <= 1;
      req_row1_col1 <= m.m11; req_row1_col2 <= m.m12; req_row1_col3 <= m.m13;
      req_row2_col2 <= m.m22; req_row3_col1 <= m.m31; req_row3_col2 <= m.m32;
      req_row3_col3 <= m.m33;
      do @(posedge clock); while (req_busy);
      pending_angles.push_back(euler_of(m, threshold_shadow));
      beats_in++;
   endtask

   task automatic drain;
      req_start <= 0;
      @(posedge clock);
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [14:0] v);
      csr_valid          <= 1;
      csr_lock_threshold <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      threshold_shadow = v;
   endtask

   function automatic logic signed [15:0] rand_elem();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(int'($urandom_range(32768)) - 16384);
         3: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic matrix_type rand_matrix();
      matrix_type m;
      m.m11 = rand_elem(); m.m12 = rand_elem(); m.m13 = rand_elem();
      m.m22 = rand_elem(); m.m31 = rand_elem(); m.m33 = rand_elem();
      // pitch sine near the lock region often
      case ($urandom_range(3))
         0: m.m32 = 16'(int'($urandom_range(8)) - 16388);
         1: m.m32 = 16'(16380 + int'($urandom_range(8)));
         default: m.m32 = rand_elem();
      endcase
      return m;
   endfunction

   row_type rows[$];

   function automatic row_type mk(logic signed [15:0] a, b, c, d, e, f, g);
      row_type r;
      r.m = '{a, b, c, d, e, f, g};
      r.known = 0;
      r.a = '{0, 0, 0, 0};
      return r;
   endfunction

   initial begin
      logic [14:0] thr_set[5] = '{15'd16382, 15'd0, 15'd16384, 15'h7fff, 15'd8000};
      int idle_set[4] = '{0, 52, 0, 24};
      row_type r;
      angles_type got;
      threshold_shadow = ThreshReset;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rows; zero matrix and saturated pitch are read off directly
      r = mk(0, 0, 0, 0, 0, 0, 0); r.known = 1; r.a = '{0, 0, 0, 0}; rows.push_back(r);
      r = mk(0, 0, 0, 0, 0, -16384, 0); r.known = 1;
      r.a = '{HalfPiQ13, 0, 0, 1}; rows.push_back(r);
      r = mk(0, 0, 0, 0, 0, 16384, 0); r.known = 1;
      r.a = '{-HalfPiQ13, 0, 0, 1}; rows.push_back(r);
      r = mk(0, 0, 0, 0, 0, 16'sh8000, 0); r.known = 1;
      r.a = '{HalfPiQ13, 0, 0, 1}; rows.push_back(r);
      rows.push_back(mk(16384, 0, 0, 16384, 0, 0, 16384));
      rows.push_back(mk(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh8000, 16'sh7fff, 16'sh8000));
      rows.push_back(mk(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                        16'sh7fff, 16'sh7fff, 16'sh7fff));
      rows.push_back(mk(-100, 5, 0, -7, 0, 0, -3));
      rows.push_back(mk(-100, -5, 0, -7, -3, 0, -1));
      rows.push_back(mk(100, 0, 16'sh8000, 0, 0, -16383, 0));
      rows.push_back(mk(100, 0, 16'sh8000, 0, 0, -16382, 0));
      rows.push_back(mk(-1, 0, 1, 0, 0, 16383, 0));
      rows.push_back(mk(0, 1, 0, 0, 1, 8192, 0));
      rows.push_back(mk(11585, -11585, 11585, 11585, -11585, -11585, 11585));
      foreach (rows[i]) begin
         send_matrix(rows[i].m, 0);
         if (rows[i].known) begin
            got = pending_angles[$];
            if (got.pitch !== rows[i].a.pitch || got.yaw !== rows[i].a.yaw ||
                got.roll !== rows[i].a.roll || got.locked !== rows[i].a.locked) begin
               errors++;
               $display("%0t: directed row %0d expected p=%0d y=%0d r=%0d l=%0d predicted p=%0d",
                  $time, i, rows[i].a.pitch, rows[i].a.yaw, rows[i].a.roll,
                  rows[i].a.locked, got.pitch);
            end
         end
      end
      drain();

      // random phases over threshold settings and sender idling
      for (int p = 0; p < 5; p++) begin
         write_threshold(thr_set[p]);
         for (int k = 0; k < 150; k++)
            send_matrix(rand_matrix(), idle_set[p % 4]);
         // sender waits for the pipeline to empty before the next setting
         drain();
      end

      $display("%0d matrices sent, %0d results checked, %0d locked, 5 thresholds",
               beats_in, beats_out, locked_seen);
      if (errors == 0 && pending_angles.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
